### rtl/dklo_pkg.sv
// Shared constants and types for the keep-last deduplication block.
package dklo_pkg;

   localparam int ITEM_W = 10;
   localparam int DEF_MAX_ITEMS = 64;
   localparam int DEF_VALUE_BITS = 10;

   // Command from the walk pipeline to the result stage.
   typedef struct packed {
      logic              hit;
      logic [ITEM_W-1:0] value;
      logic              flush;
   } emit_cmd_type;

endpackage

### rtl/dklo_ram.sv
// Single-port-write, single-port-read synchronous memory with registered read data.
module dklo_ram
   import dklo_pkg::*;
#(
   parameter int DEPTH  = DEF_MAX_ITEMS,
   parameter int ADDR_W = 6,
   parameter int DATA_W = ITEM_W
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read data holds while the read enable is low, so a stalled pipeline keeps it.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/dklo_emit.sv
// Result stage: holds the latest kept value back until the next one or the end of the walk.
module dklo_emit
   import dklo_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  emit_cmd_type      cmd,
   output logic              advance,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [ITEM_W-1:0] rsp_kept_value,
   output logic              rsp_last_of_run
);

   logic              pend_valid_ff, pend_valid_in;
   logic [ITEM_W-1:0] pend_value_ff, pend_value_in;
   logic              out_valid_ff, out_valid_in;
   logic [ITEM_W-1:0] out_value_ff, out_value_in;
   logic              out_last_ff, out_last_in;

   assign advance = !(out_valid_ff && rsp_stall);

   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_value_in = pend_value_ff;
      out_valid_in  = out_valid_ff;
      out_value_in  = out_value_ff;
      out_last_in   = out_last_ff;
      if (advance) begin
         out_valid_in = 1'b0;
         if (cmd.hit) begin
            // A newer kept value proves the held one is not the last.
            if (pend_valid_ff) begin
               out_valid_in = 1'b1;
               out_value_in = pend_value_ff;
               out_last_in  = 1'b0;
            end
            pend_valid_in = 1'b1;
            pend_value_in = cmd.value;
         end else if (cmd.flush && pend_valid_ff) begin
            out_valid_in  = 1'b1;
            out_value_in  = pend_value_ff;
            out_last_in   = 1'b1;
            pend_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_value_ff <= pend_value_in;
      out_value_ff  <= out_value_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_kept_value  = out_value_ff;
   assign rsp_last_of_run = out_last_ff;

   a_stalled_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_kept_value) && $stable(rsp_last_of_run)))
      else $error("stalled result was not held");

   a_last_empties_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_of_run) |-> !pend_valid_ff)
      else $error("a value is still held behind the last result");

   a_hit_is_held: assert property (@(posedge clock) disable iff (reset)
      (cmd.hit && advance) |=> pend_valid_ff)
      else $error("kept value was not captured");

endmodule

### rtl/dedup_keep_last_occurrence_top.sv
// Top level: load phase, walk pipeline over the item buffer and position table, result stage.
// Load: one item per cycle into both memories while fewer than MAX_ITEMS are stored.
// Walk: each stored item is read from the item buffer, its key is looked up in the position table,
//    and the result stage releases the held last value in the flush state.
// A stalled result stalls the walk.
// Synchronous reset clears the count, the state and the valid bits; memories are not cleared.
module dedup_keep_last_occurrence_top
   import dklo_pkg::*;
#(
   parameter int MAX_ITEMS  = DEF_MAX_ITEMS,
   parameter int VALUE_BITS = DEF_VALUE_BITS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [ITEM_W-1:0] req_item_value,
   input  logic              req_end_of_sequence,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [ITEM_W-1:0] rsp_kept_value,
   output logic              rsp_last_of_run
);

   localparam int KEY_BITS = (VALUE_BITS < ITEM_W) ? VALUE_BITS : ITEM_W;
   localparam int POS_W    = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
   localparam int CNT_W    = $clog2(MAX_ITEMS + 1);
   localparam int TAB_DEPTH = 1 << KEY_BITS;

   localparam logic [1:0] ST_LOAD  = 2'd0;
   localparam logic [1:0] ST_WALK  = 2'd1;
   localparam logic [1:0] ST_FLUSH = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    idx_ff, idx_in;
   logic                vb_ff, vb_in;
   logic                vc_ff, vc_in;
   logic [POS_W-1:0]    pos_b_ff, pos_b_in;
   logic [POS_W-1:0]    pos_c_ff, pos_c_in;
   logic [KEY_BITS-1:0] val_c_ff, val_c_in;

   logic                accept;
   logic                store;
   logic                issue;
   logic                advance;
   logic [KEY_BITS-1:0] key;
   logic [KEY_BITS-1:0] buf_rd;
   logic [POS_W-1:0]    tab_rd;
   emit_cmd_type        cmd;

   assign req_stall = (state_ff != ST_LOAD);
   assign accept    = req_valid && !req_stall;
   assign store     = accept && (count_ff < CNT_W'(MAX_ITEMS));
   assign key       = req_item_value[KEY_BITS-1:0];
   assign issue     = (state_ff == ST_WALK) && (idx_ff < count_ff);

   dklo_ram #(
      .DEPTH  (MAX_ITEMS),
      .ADDR_W (POS_W),
      .DATA_W (KEY_BITS)
   ) u_item_buf (
      .clock   (clock),
      .wr_en   (store),
      .wr_addr (count_ff[POS_W-1:0]),
      .wr_data (key),
      .rd_en   (advance),
      .rd_addr (idx_ff[POS_W-1:0]),
      .rd_data (buf_rd)
   );

   dklo_ram #(
      .DEPTH  (TAB_DEPTH),
      .ADDR_W (KEY_BITS),
      .DATA_W (POS_W)
   ) u_pos_tab (
      .clock   (clock),
      .wr_en   (store),
      .wr_addr (key),
      .wr_data (count_ff[POS_W-1:0]),
      .rd_en   (advance),
      .rd_addr (buf_rd),
      .rd_data (tab_rd)
   );

   // A value is kept where the table still points at its own position.
   always_comb begin
      cmd.hit   = vc_ff && (tab_rd == pos_c_ff);
      cmd.value = ITEM_W'(val_c_ff);
      cmd.flush = (state_ff == ST_FLUSH);
   end

   dklo_emit u_emit (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .advance         (advance),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kept_value  (rsp_kept_value),
      .rsp_last_of_run (rsp_last_of_run)
   );

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      idx_in   = idx_ff;
      vb_in    = vb_ff;
      vc_in    = vc_ff;
      pos_b_in = pos_b_ff;
      pos_c_in = pos_c_ff;
      val_c_in = val_c_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (store) begin
               count_in = CNT_W'(count_ff + 1'b1);
            end
            if (accept && req_end_of_sequence) begin
               state_in = ST_WALK;
               idx_in   = '0;
            end
         end
         ST_WALK: begin
            if (advance) begin
               idx_in   = issue ? CNT_W'(idx_ff + 1'b1) : idx_ff;
               vb_in    = issue;
               pos_b_in = idx_ff[POS_W-1:0];
               vc_in    = vb_ff;
               pos_c_in = pos_b_ff;
               val_c_in = buf_rd;
            end
            if (!issue && !vb_ff && !vc_ff) begin
               state_in = ST_FLUSH;
               count_in = '0;
            end
         end
         ST_FLUSH: begin
            if (advance) begin
               state_in = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         count_ff <= '0;
         vb_ff    <= 1'b0;
         vc_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         vb_ff    <= vb_in;
         vc_ff    <= vc_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff   <= idx_in;
      pos_b_ff <= pos_b_in;
      pos_c_ff <= pos_c_in;
      val_c_ff <= val_c_in;
   end

   a_end_starts_walk: assert property (@(posedge clock) disable iff (reset)
      (accept && req_end_of_sequence) |=> (state_ff == ST_WALK))
      else $error("final transfer did not start the walk");

   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |-> (idx_ff <= count_ff))
      else $error("walk index ran past the item count");

   a_no_walk_in_load: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOAD) |-> (!vb_ff && !vc_ff))
      else $error("walk pipeline busy during load");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_ITEMS))
      else $error("item count exceeds buffer capacity");

endmodule
